// ----- hdl/qrfp_pkg.sv -----
package qrfp_pkg;

    // width of packet positions and of the latched packet length
    localparam int LENGTH_BITS = 16;

    typedef logic [LENGTH_BITS-1:0] qrfp_len_t;

    // parser phases
    localparam logic [2:0] PH_MAGIC   = 3'd0;
    localparam logic [2:0] PH_LEN     = 3'd1;
    localparam logic [2:0] PH_CONTENT = 3'd2;
    localparam logic [2:0] PH_FLAGS   = 3'd3;
    localparam logic [2:0] PH_IGNORE  = 3'd4;

    // byte roles
    localparam logic [2:0] ROLE_MAGIC   = 3'd0;
    localparam logic [2:0] ROLE_LENGTH  = 3'd1;
    localparam logic [2:0] ROLE_CONTENT = 3'd2;
    localparam logic [2:0] ROLE_FLAGS   = 3'd3;
    localparam logic [2:0] ROLE_IGNORED = 3'd4;

    // packet status codes
    localparam logic [1:0] STATUS_OK          = 2'd0;
    localparam logic [1:0] STATUS_BAD_MAGIC   = 2'd1;
    localparam logic [1:0] STATUS_BAD_GENERAL = 2'd2;
    localparam logic [1:0] STATUS_BAD_RULE    = 2'd3;

    // field numbers
    localparam logic [4:0] FIELD_FIRST_GENERAL = 5'd0;
    localparam logic [4:0] FIELD_LAST_GENERAL  = 5'd8;
    localparam logic [4:0] FIELD_RULE_KEY      = 5'd9;
    localparam logic [4:0] FIELD_RULE_VALUE    = 5'd10;
    localparam logic [4:0] FIELD_PLAYER_BASE   = 5'd11;

    localparam int PLAYER_FIELDS = 6;

    // "EYE1"
    localparam logic [7:0] MAGIC_WORD [4] = '{8'h45, 8'h59, 8'h45, 8'h31};

    typedef struct packed {
        qrfp_len_t                  pos;
        qrfp_len_t                  len;
        logic [2:0]                 phase;
        logic [4:0]                 field_cnt;
        logic [7:0]                 content_left;
        logic [PLAYER_FIELDS-1:0]   pending_flags;
        logic [15:0]                player_count;
        logic [1:0]                 error_code;
    } qrfp_state_t;

    typedef struct packed {
        logic [7:0]  byte_out;
        logic [2:0]  role;
        logic [4:0]  field_id;
        logic        field_end;
        logic [15:0] player_index;
        logic        packet_end;
        logic [1:0]  status;
        logic [15:0] players_complete;
    } qrfp_result_t;

    typedef struct packed {
        logic [2:0]                 phase;
        logic [4:0]                 field_cnt;
        logic [PLAYER_FIELDS-1:0]   pending_flags;
        logic [15:0]                player_count;
    } qrfp_player_step_t;

    // move to the next selected player field, or close the record
    function automatic qrfp_player_step_t next_player_field(
        input logic [PLAYER_FIELDS-1:0] flags,
        input logic [4:0]               field_cnt,
        input logic [15:0]              player_count
    );
        qrfp_player_step_t r;
        logic              found;
        r.phase         = PH_LEN;
        r.field_cnt     = field_cnt;
        r.pending_flags = flags;
        r.player_count  = player_count;
        found           = 1'b0;
        if (flags == '0)
        begin
            r.player_count = player_count + 16'd1;
            r.phase        = PH_FLAGS;
        end
        else
        begin
            for (int i = 0; i < PLAYER_FIELDS; i++)
            begin
                if (!found && flags[i])
                begin
                    found              = 1'b1;
                    r.pending_flags[i] = 1'b0;
                    r.field_cnt        = FIELD_PLAYER_BASE + 5'(i);
                end
            end
        end
        return r;
    endfunction

endpackage

// ----- hdl/qrfp_if.sv -----
// input beat: one packet byte with the packet length
interface qrfp_byte_if;
    import qrfp_pkg::*;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic [15:0] packet_len;

    modport source (output valid, output data_byte, output packet_len, input ready);
    modport sink (input valid, input data_byte, input packet_len, output ready);
endinterface

// output beat: the byte with its tags
interface qrfp_tag_if;
    import qrfp_pkg::*;
    logic        valid;
    logic        ready;
    logic [7:0]  byte_out;
    logic [2:0]  role;
    logic [4:0]  field_id;
    logic        field_end;
    logic [15:0] player_index;
    logic        packet_end;
    logic [1:0]  status;
    logic [15:0] players_complete;

    modport source (
        output valid, output byte_out, output role, output field_id, output field_end,
        output player_index, output packet_end, output status, output players_complete,
        input ready
    );
    modport sink (
        input valid, input byte_out, input role, input field_id, input field_end,
        input player_index, input packet_end, input status, input players_complete,
        output ready
    );
endinterface

// ----- hdl/query_response_field_parser_core.sv -----
// channel   dir  beat contents
// byte_in   in   data_byte, packet_len
// tag_out   out  byte_out, role, field_id, field_end, player_index,
//                packet_end, status, players_complete
//
// one beat in, one beat out; a new byte is taken every cycle while the output is not stalled
// the output beat appears in the cycle after its input beat is taken, from the result register
// parser state advances in the same cycle the byte is taken
// rst_n clears the parser to the start of a packet and empties the result register
// a stalled output holds its beat; input is still taken if the beat leaves that cycle
module query_response_field_parser_core
    import qrfp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    qrfp_byte_if.sink    byte_in,
    qrfp_tag_if.source   tag_out
);

    qrfp_state_t  state_reg;
    qrfp_state_t  state_next;
    qrfp_result_t res_reg;
    qrfp_result_t res_next;
    logic         out_valid_reg;
    logic         take;

    qrfp_step u_step (
        .cur        (state_reg),
        .data_byte  (byte_in.data_byte),
        .packet_len (byte_in.packet_len),
        .nxt        (state_next),
        .res        (res_next)
    );

    // accept while the result register is empty or drains this cycle
    assign byte_in.ready = !out_valid_reg || tag_out.ready;
    assign take          = byte_in.valid && byte_in.ready;

    // parser state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (tag_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_reg <= res_next;
        end
    end

    assign tag_out.valid            = out_valid_reg;
    assign tag_out.byte_out         = res_reg.byte_out;
    assign tag_out.role             = res_reg.role;
    assign tag_out.field_id         = res_reg.field_id;
    assign tag_out.field_end        = res_reg.field_end;
    assign tag_out.player_index     = res_reg.player_index;
    assign tag_out.packet_end       = res_reg.packet_end;
    assign tag_out.status           = res_reg.status;
    assign tag_out.players_complete = res_reg.players_complete;

endmodule

// ----- hdl/qrfp_step.sv -----
module qrfp_step
    import qrfp_pkg::*;
(
    input  qrfp_state_t  cur,
    input  logic [7:0]   data_byte,
    input  logic [15:0]  packet_len,
    output qrfp_state_t  nxt,
    output qrfp_result_t res
);

    qrfp_len_t              len_cur;
    qrfp_len_t              len_in;
    logic                   fits;
    logic                   shortlen;
    logic                   last;
    qrfp_player_step_t      np_pending;
    qrfp_player_step_t      np_flags;

    // length of the packet: taken from the first byte, zero read as one
    assign len_in  = packet_len[LENGTH_BITS-1:0];
    assign len_cur = (cur.pos == '0) ? ((len_in == '0) ? qrfp_len_t'(1) : len_in) : cur.len;

    // a length byte fits when position plus length stays within the packet
    assign fits     = ({1'b0, cur.pos} + (LENGTH_BITS+1)'(data_byte)) <= {1'b0, len_cur};
    assign shortlen = data_byte <= 8'd1;
    assign last     = ({1'b0, cur.pos} + (LENGTH_BITS+1)'(1)) >= {1'b0, len_cur};

    assign np_pending = next_player_field(cur.pending_flags, cur.field_cnt, cur.player_count);
    assign np_flags   = next_player_field(data_byte[PLAYER_FIELDS-1:0], cur.field_cnt,
                                          cur.player_count);

    // per-byte state update and tagging
    always_comb
    begin
        nxt          = cur;
        nxt.len      = len_cur;
        res          = '0;
        res.byte_out = data_byte;
        res.role     = ROLE_IGNORED;

        unique case (cur.phase)
            PH_MAGIC:
            begin
                res.role = ROLE_MAGIC;
                if (data_byte != MAGIC_WORD[cur.pos[1:0]])
                begin
                    nxt.error_code = STATUS_BAD_MAGIC;
                    nxt.phase      = PH_IGNORE;
                end
                else if (cur.pos[1:0] == 2'd3)
                begin
                    nxt.field_cnt = FIELD_FIRST_GENERAL;
                    nxt.phase     = PH_LEN;
                end
            end
            PH_LEN:
            begin
                res.role     = ROLE_LENGTH;
                res.field_id = cur.field_cnt;
                if (cur.field_cnt <= FIELD_LAST_GENERAL)
                begin
                    if (shortlen || !fits)
                    begin
                        nxt.error_code = STATUS_BAD_GENERAL;
                        nxt.phase      = PH_IGNORE;
                    end
                    else
                    begin
                        nxt.content_left = data_byte - 8'd1;
                        nxt.phase        = PH_CONTENT;
                    end
                end
                else if (cur.field_cnt == FIELD_RULE_KEY)
                begin
                    if (shortlen || !fits)
                    begin
                        nxt.phase = PH_FLAGS;
                    end
                    else
                    begin
                        nxt.content_left = data_byte - 8'd1;
                        nxt.phase        = PH_CONTENT;
                    end
                end
                else if (cur.field_cnt == FIELD_RULE_VALUE)
                begin
                    if (shortlen || !fits)
                    begin
                        nxt.error_code = STATUS_BAD_RULE;
                        nxt.phase      = PH_IGNORE;
                    end
                    else
                    begin
                        nxt.content_left = data_byte - 8'd1;
                        nxt.phase        = PH_CONTENT;
                    end
                end
                else
                begin
                    res.player_index = cur.player_count;
                    if (shortlen)
                    begin
                        // empty player field
                        res.field_end     = 1'b1;
                        nxt.phase         = np_pending.phase;
                        nxt.field_cnt     = np_pending.field_cnt;
                        nxt.pending_flags = np_pending.pending_flags;
                        nxt.player_count  = np_pending.player_count;
                    end
                    else if (!fits)
                    begin
                        nxt.phase = PH_IGNORE;
                    end
                    else
                    begin
                        nxt.content_left = data_byte - 8'd1;
                        nxt.phase        = PH_CONTENT;
                    end
                end
            end
            PH_CONTENT:
            begin
                res.role         = ROLE_CONTENT;
                res.field_id     = cur.field_cnt;
                nxt.content_left = cur.content_left - 8'd1;
                if (cur.field_cnt >= FIELD_PLAYER_BASE)
                begin
                    res.player_index = cur.player_count;
                end
                if (cur.content_left == 8'd1)
                begin
                    res.field_end = 1'b1;
                    if (cur.field_cnt <= FIELD_LAST_GENERAL)
                    begin
                        nxt.field_cnt = cur.field_cnt + 5'd1;
                        nxt.phase     = PH_LEN;
                    end
                    else if (cur.field_cnt == FIELD_RULE_KEY)
                    begin
                        nxt.field_cnt = FIELD_RULE_VALUE;
                        nxt.phase     = PH_LEN;
                    end
                    else if (cur.field_cnt == FIELD_RULE_VALUE)
                    begin
                        nxt.field_cnt = FIELD_RULE_KEY;
                        nxt.phase     = PH_LEN;
                    end
                    else
                    begin
                        nxt.phase         = np_pending.phase;
                        nxt.field_cnt     = np_pending.field_cnt;
                        nxt.pending_flags = np_pending.pending_flags;
                        nxt.player_count  = np_pending.player_count;
                    end
                end
            end
            PH_FLAGS:
            begin
                res.role          = ROLE_FLAGS;
                res.player_index  = cur.player_count;
                nxt.phase         = np_flags.phase;
                nxt.field_cnt     = np_flags.field_cnt;
                nxt.pending_flags = np_flags.pending_flags;
                nxt.player_count  = np_flags.player_count;
            end
            default:
            begin
                res.role = ROLE_IGNORED;
            end
        endcase

        // packet end: report and return to the start state
        if (last)
        begin
            res.packet_end = 1'b1;
            res.status     = nxt.error_code;
            if (nxt.error_code == STATUS_OK)
            begin
                if (nxt.phase == PH_MAGIC)
                begin
                    res.status = STATUS_BAD_MAGIC;
                end
                else if (nxt.phase == PH_LEN && nxt.field_cnt <= FIELD_LAST_GENERAL)
                begin
                    res.status = STATUS_BAD_GENERAL;
                end
                else if (nxt.phase == PH_LEN && nxt.field_cnt == FIELD_RULE_VALUE)
                begin
                    res.status = STATUS_BAD_RULE;
                end
            end
            res.players_complete = nxt.player_count;
            nxt                  = '0;
        end
        else
        begin
            nxt.pos = cur.pos + qrfp_len_t'(1);
        end
    end

endmodule
